// File: src/rtcas_pkg.sv
package rtcas_pkg;

  localparam int unsigned ACTION_W     = 2;
  localparam int unsigned TICKS_W      = 32;
  localparam int unsigned SECONDS_W    = 32;
  localparam int unsigned PERIOD_W     = 24;
  localparam int unsigned SUBSEC_W     = 15;
  localparam int unsigned TICK_COUNT_W = 64;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 32;

  localparam logic [PERIOD_W-1:0]  PERIOD_RESET      = 24'd32768;
  localparam logic [SECONDS_W-1:0] VALID_AFTER_RESET = 32'd1514764800;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK = 2'd0,
    ACT_ARM  = 2'd1,
    ACT_SET  = 2'd2
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SECOND_PERIOD = 2'd0,
    CFG_VALID_AFTER   = 2'd1
  } cfg_idx_e;

  // one-hot strobes for the request being retired this cycle
  typedef struct packed {
    logic tick;
    logic arm;
    logic set;
  } cmd_t;

endpackage

// File: src/rtc_with_alarm_slots.sv
// Tick counter with a one-second heartbeat compare and ALARM_SLOTS alarm slots.
// Each request is a tick, an alarm arm, a seconds load or unused code 3, and
// each returns one result with the time after the request. A new request is
// taken every clock unless a full result register is stalled; the single
// compute pass in front of the result register works on the request held in
// the input register. The rate is set by that one compute pass, which reads and
// updates counter, heartbeat and slot state in the same cycle. Configuration
// (second_period, valid_after) goes through a plain write port; the user must
// write it only while no request is in flight, which the block does not check.
module rtc_with_alarm_slots import rtcas_pkg::*; #(
  parameter int unsigned ALARM_SLOTS  = 3,
  parameter int unsigned COUNTER_BITS = 24,
  localparam int unsigned SLOT_W      = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  // request channel
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [ACTION_W-1:0]     action_i,
  input  logic [TICKS_W-1:0]      ticks_until_i,
  input  logic [SECONDS_W-1:0]    new_seconds_i,
  // result channel
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [TICK_COUNT_W-1:0] tick_count_o,
  output logic [SUBSEC_W-1:0]     subsecond_o,
  output logic [SECONDS_W-1:0]    seconds_o,
  output logic                    time_valid_o,
  output logic                    heartbeat_o,
  output logic [ALARM_SLOTS-1:0]  alarm_fired_o,
  output logic                    alarm_granted_o,
  output logic [SLOT_W-1:0]       alarm_slot_o
);

  // configuration registers
  logic [PERIOD_W-1:0]  period_q;
  logic [SECONDS_W-1:0] valid_after_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q      <= PERIOD_RESET;
      valid_after_q <= VALID_AFTER_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SECOND_PERIOD: period_q      <= cfg_data_i[PERIOD_W-1:0];
        CFG_VALID_AFTER:   valid_after_q <= cfg_data_i;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // input register; the compute pass retires it whenever the result
  // register is empty or being drained this cycle
  logic                 in_full_q;
  logic [ACTION_W-1:0]  action_q;
  logic [TICKS_W-1:0]   ticks_q;
  logic [SECONDS_W-1:0] nsec_q;
  logic                 out_valid_q;
  logic                 advance, fire, accept;

  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_full_q && advance;
  assign in_stall_o = in_full_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q <= 1'b0;
    end else if (accept) begin
      in_full_q <= 1'b1;
    end else if (fire) begin
      in_full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q <= action_i;
      ticks_q  <= ticks_until_i;
      nsec_q   <= new_seconds_i;
    end
  end

  // decode; action 3 retires with no state change
  cmd_t cmd;

  always_comb begin
    cmd = '0;
    case (action_e'(action_q))
      ACT_TICK: cmd.tick = fire;
      ACT_ARM:  cmd.arm  = fire;
      ACT_SET:  cmd.set  = fire;
      default:  cmd      = '0;
    endcase
  end

  // compute pass
  logic [COUNTER_BITS-1:0] cnt, cnt_inc;
  logic [TICK_COUNT_W-1:0] tick_count_nx;
  logic [SUBSEC_W-1:0]     subsec_nx;
  logic [SECONDS_W-1:0]    seconds_nx;
  logic                    hb_nx;
  logic [ALARM_SLOTS-1:0]  fired_nx;
  logic                    granted_nx;
  logic [SLOT_W-1:0]       slot_nx;

  rtcas_timebase #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_timebase (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .period_i      (period_q),
    .new_seconds_i (nsec_q),
    .cnt_o         (cnt),
    .cnt_inc_o     (cnt_inc),
    .tick_count_o  (tick_count_nx),
    .subsecond_o   (subsec_nx),
    .seconds_o     (seconds_nx),
    .heartbeat_o   (hb_nx)
  );

  rtcas_alarm_slots #(
    .ALARM_SLOTS  (ALARM_SLOTS),
    .COUNTER_BITS (COUNTER_BITS),
    .SLOT_W       (SLOT_W)
  ) u_alarms (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cnt_i         (cnt),
    .cnt_inc_i     (cnt_inc),
    .ticks_until_i (ticks_q),
    .fired_o       (fired_nx),
    .granted_o     (granted_nx),
    .slot_o        (slot_nx)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_full_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      tick_count_o    <= tick_count_nx;
      subsecond_o     <= subsec_nx;
      seconds_o       <= seconds_nx;
      time_valid_o    <= (seconds_nx > valid_after_q);
      heartbeat_o     <= hb_nx;
      alarm_fired_o   <= fired_nx;
      alarm_granted_o <= granted_nx;
      alarm_slot_o    <= slot_nx;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: src/rtcas_timebase.sv
module rtcas_timebase import rtcas_pkg::*; #(
  parameter int unsigned COUNTER_BITS = 24
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cmd_t                    cmd_i,
  input  logic [PERIOD_W-1:0]     period_i,
  input  logic [SECONDS_W-1:0]    new_seconds_i,
  output logic [COUNTER_BITS-1:0] cnt_o,
  output logic [COUNTER_BITS-1:0] cnt_inc_o,
  output logic [TICK_COUNT_W-1:0] tick_count_o,
  output logic [SUBSEC_W-1:0]     subsecond_o,
  output logic [SECONDS_W-1:0]    seconds_o,
  output logic                    heartbeat_o
);

  localparam int unsigned OVF_W = TICK_COUNT_W - COUNTER_BITS;
  localparam logic [31:0] HB_RESET_EXT = 32'(PERIOD_RESET);

  logic [COUNTER_BITS-1:0] cnt_q, cnt_d, cnt_inc;
  logic [OVF_W-1:0]        ovf_q, ovf_d;
  logic [COUNTER_BITS-1:0] hb_cmp_q, hb_cmp_d;
  logic [SECONDS_W-1:0]    secs_q, secs_d;
  logic [31:0]             period_ext, cnt_ext;
  logic                    hb;

  assign period_ext = 32'(period_i);
  assign cnt_inc    = cnt_q + COUNTER_BITS'(1);
  assign hb         = cmd_i.tick && (cnt_inc == hb_cmp_q);

  always_comb begin
    cnt_d    = cnt_q;
    ovf_d    = ovf_q;
    hb_cmp_d = hb_cmp_q;
    secs_d   = secs_q;
    if (cmd_i.tick) begin
      cnt_d = cnt_inc;
      if (cnt_inc == '0) begin
        ovf_d = ovf_q + OVF_W'(1);
      end
    end
    if (hb) begin
      // period zero leaves the compare where it is
      hb_cmp_d = hb_cmp_q + period_ext[COUNTER_BITS-1:0];
      secs_d   = secs_q + SECONDS_W'(1);
    end else if (cmd_i.set) begin
      secs_d = new_seconds_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      ovf_q    <= '0;
      hb_cmp_q <= HB_RESET_EXT[COUNTER_BITS-1:0];
      secs_q   <= '0;
    end else begin
      cnt_q    <= cnt_d;
      ovf_q    <= ovf_d;
      hb_cmp_q <= hb_cmp_d;
      secs_q   <= secs_d;
    end
  end

  assign cnt_ext      = 32'(cnt_d);
  assign cnt_o        = cnt_q;
  assign cnt_inc_o    = cnt_inc;
  assign tick_count_o = {ovf_d, cnt_d};
  assign subsecond_o  = cnt_ext[SUBSEC_W-1:0];
  assign seconds_o    = secs_d;
  assign heartbeat_o  = hb;

endmodule

// File: src/rtcas_alarm_slots.sv
module rtcas_alarm_slots import rtcas_pkg::*; #(
  parameter int unsigned ALARM_SLOTS  = 3,
  parameter int unsigned COUNTER_BITS = 24,
  parameter int unsigned SLOT_W       = 2
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cmd_t                    cmd_i,
  input  logic [COUNTER_BITS-1:0] cnt_i,
  input  logic [COUNTER_BITS-1:0] cnt_inc_i,
  input  logic [TICKS_W-1:0]      ticks_until_i,
  output logic [ALARM_SLOTS-1:0]  fired_o,
  output logic                    granted_o,
  output logic [SLOT_W-1:0]       slot_o
);

  localparam int unsigned WRAP_W = TICKS_W + 1 - COUNTER_BITS;

  logic [WRAP_W-1:0]       wraps_q [ALARM_SLOTS];
  logic [WRAP_W-1:0]       wraps_d [ALARM_SLOTS];
  logic [COUNTER_BITS-1:0] cmp_q   [ALARM_SLOTS];
  logic [COUNTER_BITS-1:0] cmp_d   [ALARM_SLOTS];
  logic [WRAP_W-1:0]       arm_wraps;
  logic [COUNTER_BITS-1:0] arm_cmp;
  logic [SLOT_W-1:0]       sel;
  logic                    found;

  assign arm_wraps = WRAP_W'(ticks_until_i >> COUNTER_BITS) + WRAP_W'(1);
  assign arm_cmp   = COUNTER_BITS'(cnt_i + ticks_until_i[COUNTER_BITS-1:0]);

  // lowest free slot wins
  always_comb begin
    sel   = '0;
    found = 1'b0;
    for (int i = ALARM_SLOTS - 1; i >= 0; i--) begin
      if (wraps_q[i] == '0) begin
        sel   = SLOT_W'(i);
        found = 1'b1;
      end
    end
  end

  always_comb begin
    fired_o = '0;
    for (int i = 0; i < ALARM_SLOTS; i++) begin
      wraps_d[i] = wraps_q[i];
      cmp_d[i]   = cmp_q[i];
      if (cmd_i.tick && (wraps_q[i] != '0) && (cnt_inc_i == cmp_q[i])) begin
        wraps_d[i] = wraps_q[i] - WRAP_W'(1);
        fired_o[i] = (wraps_q[i] == WRAP_W'(1));
      end
    end
    if (cmd_i.arm && found) begin
      wraps_d[sel] = arm_wraps;
      cmp_d[sel]   = arm_cmp;
    end
  end

  assign granted_o = cmd_i.arm && found;
  assign slot_o    = granted_o ? sel : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ALARM_SLOTS; i++) begin
        wraps_q[i] <= '0;
        cmp_q[i]   <= '0;
      end
    end else begin
      for (int i = 0; i < ALARM_SLOTS; i++) begin
        wraps_q[i] <= wraps_d[i];
        cmp_q[i]   <= cmp_d[i];
      end
    end
  end

endmodule

// File: src/rtcas_checker.sv
module rtcas_checker import rtcas_pkg::*; #(
  parameter int unsigned ALARM_SLOTS  = 3,
  parameter int unsigned COUNTER_BITS = 24,
  parameter int unsigned SLOT_W       = 2
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic [TICK_COUNT_W-1:0] tick_count_o,
  input logic [SUBSEC_W-1:0]     subsecond_o,
  input logic                    heartbeat_o,
  input logic [ALARM_SLOTS-1:0]  alarm_fired_o,
  input logic                    alarm_granted_o,
  input logic [SLOT_W-1:0]       alarm_slot_o
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(tick_count_o))
    else $error("stalled result changed");

  // tick outcomes and arm outcomes never share a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (heartbeat_o || (alarm_fired_o != '0)) |-> !alarm_granted_o)
    else $error("tick flags and grant in one result");

  // slot index is zero unless granted, and names a real slot when granted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (alarm_granted_o && (32'(alarm_slot_o) < ALARM_SLOTS)) ||
                    (!alarm_granted_o && (alarm_slot_o == '0)))
    else $error("bad alarm slot");

  // subsecond is the low counter bits of the tick count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (COUNTER_BITS < SUBSEC_W) ||
                    (subsecond_o == tick_count_o[SUBSEC_W-1:0]))
    else $error("subsecond disagrees with tick count");

endmodule

bind rtc_with_alarm_slots rtcas_checker #(
  .ALARM_SLOTS  (ALARM_SLOTS),
  .COUNTER_BITS (COUNTER_BITS),
  .SLOT_W       (SLOT_W)
) u_rtcas_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .tick_count_o    (tick_count_o),
  .subsecond_o     (subsecond_o),
  .heartbeat_o     (heartbeat_o),
  .alarm_fired_o   (alarm_fired_o),
  .alarm_granted_o (alarm_granted_o),
  .alarm_slot_o    (alarm_slot_o)
);

// File: dv/rtc_with_alarm_slots_checker.sv
module rtc_with_alarm_slots_checker import rtcas_pkg::*; #(
  parameter int unsigned NUM_SLOTS = 3,
  parameter int unsigned CNT_BITS  = 24,
  parameter int unsigned SLOT_BITS = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic [ACTION_W-1:0]     action_i,
  input  logic [TICKS_W-1:0]      ticks_until_i,
  input  logic [SECONDS_W-1:0]    new_seconds_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic [TICK_COUNT_W-1:0] tick_count_i,
  input  logic [SUBSEC_W-1:0]     subsecond_i,
  input  logic [SECONDS_W-1:0]    seconds_i,
  input  logic                    time_valid_i,
  input  logic                    heartbeat_i,
  input  logic [NUM_SLOTS-1:0]    alarm_fired_i,
  input  logic                    alarm_granted_i,
  input  logic [SLOT_BITS-1:0]    alarm_slot_i,
  output int                      fail_cnt_o,
  output int                      pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [TICK_COUNT_W-1:0] tick_count;
    logic [SUBSEC_W-1:0]     subsecond;
    logic [SECONDS_W-1:0]    seconds;
    logic                    time_valid;
    logic                    heartbeat;
    logic [NUM_SLOTS-1:0]    alarm_fired;
    logic                    alarm_granted;
    logic [SLOT_BITS-1:0]    alarm_slot;
  } time_report_t;

  // shadow of the block's registers and time state
  logic [PERIOD_W-1:0]          period_q;
  logic [SECONDS_W-1:0]         valid_after_q;
  logic [CNT_BITS-1:0]          cnt_q;
  logic [TICK_COUNT_W-CNT_BITS-1:0] ovf_q;
  logic [CNT_BITS-1:0]          hb_cmp_q;
  logic [SECONDS_W-1:0]         epoch_q;
  logic [CNT_BITS-1:0]          alarm_cmp_q [NUM_SLOTS];
  logic [TICKS_W:0]             wraps_q     [NUM_SLOTS];

  time_report_t due_reports[$];

  function automatic time_report_t advance_rtc(logic [ACTION_W-1:0] act,
                                               logic [TICKS_W-1:0] ticks,
                                               logic [SECONDS_W-1:0] secs);
    time_report_t r;
    int i;
    bit done;
    r = '0;
    done = 1'b0;
    case (act)
      ACT_TICK: begin
        cnt_q = cnt_q + 1'b1;
        if (cnt_q == '0) ovf_q = ovf_q + 1'b1;
        if (cnt_q == hb_cmp_q) begin
          r.heartbeat = 1'b1;
          hb_cmp_q = hb_cmp_q + CNT_BITS'(period_q);
          epoch_q  = epoch_q + 1'b1;
        end
        for (i = 0; i < NUM_SLOTS; i++) begin
          if (wraps_q[i] != 0 && cnt_q == alarm_cmp_q[i]) begin
            wraps_q[i] = wraps_q[i] - 1'b1;
            if (wraps_q[i] == 0) r.alarm_fired[i] = 1'b1;
          end
        end
      end
      ACT_ARM: begin
        // lowest free slot wins
        for (i = 0; i < NUM_SLOTS; i++) begin
          if (!done && wraps_q[i] == 0) begin
            wraps_q[i]     = (ticks >> CNT_BITS) + 1'b1;
            alarm_cmp_q[i] = cnt_q + CNT_BITS'(ticks);
            r.alarm_granted = 1'b1;
            r.alarm_slot    = SLOT_BITS'(i);
            done = 1'b1;
          end
        end
      end
      ACT_SET: epoch_q = secs;
      default: ;
    endcase
    r.tick_count = {ovf_q, cnt_q};
    r.subsecond  = SUBSEC_W'(cnt_q);
    r.seconds    = epoch_q;
    r.time_valid = (epoch_q > valid_after_q);
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      fail_cnt_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    time_report_t want;
    if (!rst_ni) begin
      period_q      = PERIOD_RESET;
      valid_after_q = VALID_AFTER_RESET;
      cnt_q         = '0;
      ovf_q         = '0;
      hb_cmp_q      = CNT_BITS'(PERIOD_RESET);
      epoch_q       = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        alarm_cmp_q[i] = '0;
        wraps_q[i]     = '0;
      end
      due_reports.delete();
      fail_cnt_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_SECOND_PERIOD: period_q = cfg_data_i[PERIOD_W-1:0];
          CFG_VALID_AFTER:   valid_after_q = cfg_data_i;
          default: ;
        endcase
      end
      // drain first: a result always belongs to an earlier request
      if (out_valid_i && !out_stall_i) begin
        if (due_reports.size() == 0) begin
          $error("result with no request outstanding");
          fail_cnt_o++;
        end else begin
          want = due_reports.pop_front();
          check_field("tick_count", want.tick_count, tick_count_i);
          check_field("subsecond", want.subsecond, subsecond_i);
          check_field("seconds", want.seconds, seconds_i);
          check_field("time_valid", want.time_valid, time_valid_i);
          check_field("heartbeat", want.heartbeat, heartbeat_i);
          check_field("alarm_fired", want.alarm_fired, alarm_fired_i);
          check_field("alarm_granted", want.alarm_granted, alarm_granted_i);
          check_field("alarm_slot", want.alarm_slot, alarm_slot_i);
        end
      end
      if (in_valid_i && !in_stall_i)
        due_reports.push_back(advance_rtc(action_i, ticks_until_i, new_seconds_i));
    end
    pending_o = due_reports.size();
  end

endmodule

// File: dv/rtc_with_alarm_slots_tb.sv
module rtc_with_alarm_slots_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rtcas_pkg::*;

  localparam int unsigned NUM_SLOTS   = 3;
  localparam int unsigned CNT_BITS    = 24;
  localparam int unsigned SLOT_BITS   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  // action code 3 is unused by the block: it must leave all state alone
  localparam logic [ACTION_W-1:0]  ACT_NOP   = 2'd3;
  // register index past the end of the map: writes are dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int unsigned NUM_PHASES  = 6;
  localparam int unsigned PHASE_ITEMS = 140;
  localparam int unsigned HOLD_CYCLES = 60;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;
  logic                    in_valid;
  logic                    in_stall;
  logic [ACTION_W-1:0]     action;
  logic [TICKS_W-1:0]      ticks_until;
  logic [SECONDS_W-1:0]    new_seconds;
  logic                    out_valid;
  logic                    out_stall;
  logic [TICK_COUNT_W-1:0] tick_count;
  logic [SUBSEC_W-1:0]     subsecond;
  logic [SECONDS_W-1:0]    seconds;
  logic                    time_valid;
  logic                    heartbeat;
  logic [NUM_SLOTS-1:0]    alarm_fired;
  logic                    alarm_granted;
  logic [SLOT_BITS-1:0]    alarm_slot;

  int fail_cnt;
  int pending;

  // gap-pattern state: each side alternates dense runs and gappy runs
  int snd_run = 0;
  bit snd_dense = 1'b0;
  int rcv_run = 0;
  bit rcv_dense = 1'b0;
  // last valid_after written, used to aim seconds loads at the threshold
  logic [SECONDS_W-1:0] valid_after_now = VALID_AFTER_RESET;

  always #1 clk = ~clk;

  rtc_with_alarm_slots #(
    .ALARM_SLOTS (NUM_SLOTS),
    .COUNTER_BITS(CNT_BITS)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .action_i       (action),
    .ticks_until_i  (ticks_until),
    .new_seconds_i  (new_seconds),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .tick_count_o   (tick_count),
    .subsecond_o    (subsecond),
    .seconds_o      (seconds),
    .time_valid_o   (time_valid),
    .heartbeat_o    (heartbeat),
    .alarm_fired_o  (alarm_fired),
    .alarm_granted_o(alarm_granted),
    .alarm_slot_o   (alarm_slot)
  );

  rtc_with_alarm_slots_checker #(
    .NUM_SLOTS(NUM_SLOTS),
    .CNT_BITS (CNT_BITS)
  ) u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .action_i       (action),
    .ticks_until_i  (ticks_until),
    .new_seconds_i  (new_seconds),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .tick_count_i   (tick_count),
    .subsecond_i    (subsecond),
    .seconds_i      (seconds),
    .time_valid_i   (time_valid),
    .heartbeat_i    (heartbeat),
    .alarm_fired_i  (alarm_fired),
    .alarm_granted_i(alarm_granted),
    .alarm_slot_i   (alarm_slot),
    .fail_cnt_o     (fail_cnt),
    .pending_o      (pending)
  );

  // Per-request wait, drawn at random. Each side switches between dense runs
  // (no idling at all) and gappy runs every 8..40 requests.
  function automatic int draw_gap(inout int run_left, inout bit dense);
    if (run_left == 0) begin
      dense    = ($urandom_range(0, 3) == 0);
      run_left = $urandom_range(8, 40);
    end
    run_left--;
    return dense ? 0 : $urandom_range(0, 13);
  endfunction

  // Offer one request. Entered and left at a falling edge. With no gap the
  // valid simply stays high and the payload moves on to the next request.
  task automatic send_req(logic [ACTION_W-1:0] act, logic [TICKS_W-1:0] ticks,
                          logic [SECONDS_W-1:0] secs);
    int gap;
    gap = draw_gap(snd_run, snd_dense);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    action      <= act;
    ticks_until <= ticks;
    new_seconds <= secs;
    do @(posedge clk); while (!(in_valid && !in_stall));
    @(negedge clk);
  endtask

  // Drop valid and wait until every outstanding result is back, then wait out
  // spare cycles so the block is truly idle (two-stage pipe).
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // One-cycle write strobe, dropped again before the task returns, so back-to-back
  // writes never raise and drop the strobe in the same step.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Result sink. Stall is drawn per result; every 300 results or so it
  // holds off for a long stretch while requests keep coming, which backs
  // the pipe up until the block stalls its request side.
  initial begin : result_sink
    int gap;
    int taken;
    out_stall = 1'b0;
    taken = 0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      gap = draw_gap(rcv_run, rcv_dense);
      if (taken % 300 == 150) gap = HOLD_CYCLES;
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      taken++;
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int ph;
    int pick;
    logic [CFG_DATA_W-1:0] period_w;
    logic [SECONDS_W-1:0]  secs;
    logic [TICKS_W-1:0]    junk_t;
    logic [SECONDS_W-1:0]  junk_s;

    in_valid    = 1'b0;
    action      = ACT_TICK;
    ticks_until = '0;
    new_seconds = '0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_SECOND_PERIOD;
    cfg_data    = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ---- directed: reset config, counter near zero ----
    send_req(ACT_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);   // unused code reports state only
    send_req(ACT_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(ACT_SET, '0, 32'h0000_0000);
    send_req(ACT_SET, '0, 32'hFFFF_FFFF);              // time valid, top of range
    send_req(ACT_SET, '0, VALID_AFTER_RESET);          // equal to threshold: not valid
    send_req(ACT_SET, '0, VALID_AFTER_RESET + 1);      // just above threshold
    // fill all slots, two of them on the same compare value
    send_req(ACT_ARM, 32'd2, '0);
    send_req(ACT_ARM, 32'd2, '0);
    send_req(ACT_ARM, 32'd9, '0);
    send_req(ACT_ARM, 32'd1, '0);                      // no slot free
    send_req(ACT_TICK, '0, '0);
    send_req(ACT_TICK, '0, '0);                        // slots 0 and 1 fire together
    send_req(ACT_ARM, 32'd1, '0);                      // slot 0 is lowest free again
    send_req(ACT_TICK, '0, '0);
    send_req(ACT_NOP, '0, '0);
    repeat (7) send_req(ACT_TICK, '0, '0);             // slot 2 runs out

    // ---- random phases over a spread of settings ----
    // The heartbeat compare never moves back, so the two settings that push
    // it out of reach (largest period, zero period) come last.
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      case (ph)
        0: begin
          period_w = 32'd3;
          valid_after_now = $urandom;
        end
        1: begin
          period_w = 32'd7;
          valid_after_now = '0;
        end
        2: begin
          period_w = $urandom_range(1, 20);
          valid_after_now = '1;
        end
        3: begin
          // junk above bit 23 must be dropped by the period register
          period_w = ($urandom & 32'hFF00_0000) | 32'd5;
          valid_after_now = $urandom;
        end
        4: begin
          period_w = 32'h00FF_FFFF;
          valid_after_now = $urandom;
        end
        default: begin
          period_w = 32'd0;                             // heartbeat compare stays put
          valid_after_now = VALID_AFTER_RESET;
        end
      endcase
      write_reg(CFG_SECOND_PERIOD, period_w);
      write_reg(CFG_VALID_AFTER, valid_after_now);
      if (ph == 3) write_reg(CFG_SPARE, $urandom);

      repeat (PHASE_ITEMS) begin
        pick   = $urandom_range(0, 99);
        junk_t = $urandom;
        junk_s = $urandom;
        if (pick < 58) begin
          send_req(ACT_TICK, junk_t, junk_s);
        end else if (pick < 78) begin
          // short alarms only: they complete within the run and free the slot
          send_req(ACT_ARM, $urandom_range(1, 40), junk_s);
        end else if (pick < 95) begin
          case ($urandom_range(0, 3))
            0:       secs = $urandom;
            1:       secs = valid_after_now + $urandom_range(0, 4) - 2;
            2:       secs = 32'hFFFF_FFFF - $urandom_range(0, 3);   // seconds rollover
            default: secs = $urandom_range(0, 5);
          endcase
          send_req(ACT_SET, junk_t, secs);
        end else begin
          send_req(ACT_NOP, junk_t, junk_s);
        end
      end
    end

    // ---- closing: alarms that can never complete in this run ----
    // Left to the end because they pin their slots for good.
    repeat (45) send_req(ACT_TICK, $urandom, $urandom);   // every short alarm done
    send_req(ACT_ARM, 32'h0000_0000, $urandom);          // a full counter cycle away
    send_req(ACT_ARM, 32'hFFFF_FFFF, $urandom);          // most wraps
    send_req(ACT_ARM, 32'h00FF_FFFF, $urandom);
    send_req(ACT_ARM, $urandom, $urandom);               // all slots busy
    repeat (4) send_req(ACT_TICK, $urandom, $urandom);
    send_req(ACT_ARM, 32'd1, $urandom);                  // still busy
    send_req(ACT_SET, $urandom, 32'hFFFF_FFFF);
    send_req(ACT_TICK, $urandom, $urandom);

    settle();
    if (fail_cnt == 0 && pending == 0) begin
      $display("rtc_with_alarm_slots_tb OK");
    end else begin
      $display("rtc_with_alarm_slots_tb NOT OK");
    end
    $finish;
  end

  // Watchdog: well over ten times the slowest legal run.
  initial begin : watchdog
    #1_000_000;
    $display("rtc_with_alarm_slots_tb NOT OK");
    $finish;
  end

endmodule

// File: sim.f
src/rtcas_pkg.sv
src/rtcas_timebase.sv
src/rtcas_alarm_slots.sv
src/rtc_with_alarm_slots.sv
src/rtcas_checker.sv
dv/rtc_with_alarm_slots_checker.sv
dv/rtc_with_alarm_slots_tb.sv
